### src/rrtp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the round-robin thread picker.
// Depends on nothing; used by rrtp_list and round_robin_thread_picker.

package rrtp_pkg;

  // Queue geometry.
  localparam int unsigned MaxThreads = 16;
  localparam int unsigned IdW        = $clog2(MaxThreads);
  localparam int unsigned CntW       = $clog2(MaxThreads + 1);
  localparam int unsigned MaskW      = 16;

  typedef logic [IdW-1:0]   id_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [MaskW-1:0] mask_t;

  // Request codes.
  typedef logic [1:0] req_t;
  localparam req_t ReqAdd    = 2'd0;
  localparam req_t ReqRemove = 2'd1;
  localparam req_t ReqPick   = 2'd2;

  // Status codes.
  typedef logic [1:0] status_t;
  localparam status_t StatOk      = 2'd0;
  localparam status_t StatFull    = 2'd1;
  localparam status_t StatDup     = 2'd2;
  localparam status_t StatMissing = 2'd3;

  // What the shared read and compare unit reports about one queue entry.
  typedef struct packed {
    id_t  id;       // id stored at the read address
    logic key_hit;  // stored id equals the search key
    logic run_hit;  // stored id is runnable under the latched mask
  } rd_res_t;

endpackage

### src/rrtp_list.sv
`timescale 1ns / 1ps
// Run queue storage with one write port, one read port and the shared compare unit.
// Depends on rrtp_pkg.

module rrtp_list (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  rrtp_pkg::id_t    wr_addr_i,
  input  rrtp_pkg::id_t    wr_data_i,
  input  rrtp_pkg::id_t    rd_addr_i,
  input  rrtp_pkg::id_t    key_i,
  input  rrtp_pkg::mask_t  mask_i,
  output rrtp_pkg::rd_res_t rd_o
);
  import rrtp_pkg::*;

  // Queue entries, head first; contents are meaningless until written.
  id_t list_q [MaxThreads];

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      list_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Single read port feeding the key compare and the runnable test.
  always_comb begin
    rd_o.id      = list_q[rd_addr_i];
    rd_o.key_hit = (list_q[rd_addr_i] == key_i);
    rd_o.run_hit = mask_i[list_q[rd_addr_i]];
  end

endmodule

### src/round_robin_thread_picker.sv
`timescale 1ns / 1ps
// Round-robin thread picker built on rrtp_pkg and rrtp_list: run queue plus current thread.
// Each request first finds its id or the current thread where needed, then closes a gap or
// picks, then counts runnable ids, all through the single queue read port.
// Throughput: one request at a time; a new word is taken once the sequencer is idle, even
// while the previous result waits in the output register. Reset (rst_ni low, async): empty.

module round_robin_thread_picker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] thread_id, [19:4] runnable_mask, [23:20] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] picked_valid, [4:1] picked_id, [5] current_valid, [9:6] current_id,
  // [14:10] queue_count, [19:15] runnable_count, [21:20] status, [23:22] zero
  output logic [23:0] m_axis_tdata
);
  import rrtp_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StFind,
    StShift,
    StPick,
    StCount,
    StDone
  } state_e;

  state_e  state_q;
  req_t    req_q;
  id_t     id_q;
  mask_t   mask_q;
  cnt_t    count_q;
  id_t     cur_q;
  logic    held_q;
  id_t     idx_q;
  id_t     steps_q;
  cnt_t    acc_q;
  logic    picked_valid_q;
  id_t     picked_id_q;
  status_t status_q;
  logic        m_valid_q;
  logic [23:0] m_data_q;

  rd_res_t rd;
  id_t     rd_addr;
  id_t     key;
  logic    wr_en;
  id_t     wr_addr;
  id_t     wr_data;
  cnt_t    last;
  logic    idx_last;
  logic    steps_last;
  logic    shift_last;
  logic    found;
  logic    find_done;

  // Scan bookkeeping shared by all phases.
  always_comb begin
    last       = count_q - cnt_t'(1);
    idx_last   = (cnt_t'(idx_q) == last);
    steps_last = (cnt_t'(steps_q) == last);
    shift_last = ((cnt_t'(idx_q) + cnt_t'(1)) == last);
    found      = (count_q != '0) && rd.key_hit;
    find_done  = found || (count_q == '0) || idx_last;
  end

  // Read address and search key for the shared unit.
  always_comb begin
    rd_addr = (state_q == StShift) ? (idx_q + id_t'(1)) : idx_q;
    key     = (req_q == ReqPick) ? cur_q : id_q;
  end

  // Write port: append on an accepted add, move one entry down while closing a gap.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IdW-1:0];
    wr_data = id_q;
    if (state_q == StShift) begin
      wr_en   = 1'b1;
      wr_addr = idx_q;
      wr_data = rd.id;
    end else if (state_q == StFind && find_done && req_q == ReqAdd && !found &&
                 count_q != cnt_t'(MaxThreads)) begin
      wr_en = 1'b1;
    end
  end

  rrtp_list u_list (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .key_i     (key),
    .mask_i    (mask_q),
    .rd_o      (rd)
  );

  // Sequencer, queue state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      req_q          <= ReqAdd;
      id_q           <= '0;
      mask_q         <= '0;
      count_q        <= '0;
      cur_q          <= '0;
      held_q         <= 1'b0;
      idx_q          <= '0;
      steps_q        <= '0;
      acc_q          <= '0;
      picked_valid_q <= 1'b0;
      picked_id_q    <= '0;
      status_q       <= StatOk;
      m_valid_q      <= 1'b0;
      m_data_q       <= '0;
    end else begin
      // The consumer took the pending word and no new one is loaded now.
      if (m_valid_q && m_axis_tready && state_q != StDone) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            req_q          <= s_axis_tuser;
            id_q           <= s_axis_tdata[IdW-1:0];
            mask_q         <= s_axis_tdata[IdW +: MaskW];
            idx_q          <= '0;
            steps_q        <= '0;
            acc_q          <= '0;
            picked_valid_q <= 1'b0;
            picked_id_q    <= '0;
            status_q       <= StatOk;
            case (s_axis_tuser)
              ReqAdd, ReqRemove: begin
                state_q <= StFind;
              end
              ReqPick: begin
                if (count_q == '0) begin
                  held_q  <= 1'b0;
                  cur_q   <= '0;
                  state_q <= StCount;
                end else if (held_q) begin
                  state_q <= StFind;
                end else begin
                  state_q <= StPick;
                end
              end
              default: begin
                state_q <= StCount;
              end
            endcase
          end
        end

        // Look for the key; idx_q holds its position when found.
        StFind: begin
          if (find_done) begin
            case (req_q)
              ReqAdd: begin
                if (found) begin
                  status_q <= StatDup;
                end else if (count_q == cnt_t'(MaxThreads)) begin
                  status_q <= StatFull;
                end else begin
                  count_q <= count_q + cnt_t'(1);
                end
                idx_q   <= '0;
                state_q <= StCount;
              end
              ReqRemove: begin
                if (!found) begin
                  status_q <= StatMissing;
                  idx_q    <= '0;
                  state_q  <= StCount;
                end else begin
                  if (held_q && cur_q == id_q) begin
                    held_q <= 1'b0;
                    cur_q  <= '0;
                  end
                  if (idx_last) begin
                    count_q <= count_q - cnt_t'(1);
                    idx_q   <= '0;
                    state_q <= StCount;
                  end else begin
                    state_q <= StShift;
                  end
                end
              end
              default: begin
                // Pick starts after the current thread, or at the head.
                idx_q   <= (found && !idx_last) ? (idx_q + id_t'(1)) : '0;
                steps_q <= '0;
                state_q <= StPick;
              end
            endcase
          end else begin
            idx_q <= idx_q + id_t'(1);
          end
        end

        // Close the gap one entry per cycle.
        StShift: begin
          if (shift_last) begin
            count_q <= count_q - cnt_t'(1);
            idx_q   <= '0;
            state_q <= StCount;
          end else begin
            idx_q <= idx_q + id_t'(1);
          end
        end

        // Cyclic scan for the first runnable id.
        StPick: begin
          if (rd.run_hit) begin
            cur_q          <= rd.id;
            held_q         <= 1'b1;
            picked_valid_q <= 1'b1;
            picked_id_q    <= rd.id;
            idx_q          <= '0;
            state_q        <= StCount;
          end else if (steps_last) begin
            idx_q   <= '0;
            state_q <= StCount;
          end else begin
            steps_q <= steps_q + id_t'(1);
            idx_q   <= idx_last ? '0 : (idx_q + id_t'(1));
          end
        end

        // Count queued ids that are runnable.
        StCount: begin
          if (count_q == '0) begin
            state_q <= StDone;
          end else begin
            acc_q <= acc_q + cnt_t'(rd.run_hit);
            if (idx_last) begin
              state_q <= StDone;
            end else begin
              idx_q <= idx_q + id_t'(1);
            end
          end
        end

        // Hand the result to the output register once it is free.
        StDone: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {2'b00, status_q, acc_q, count_q, cur_q, held_q,
                          picked_id_q, picked_valid_q};
            state_q   <= StIdle;
          end
        end

        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The queue never grows past its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(MaxThreads))
    else $error("queue count beyond capacity");

  // Only one request is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new word taken while a request is in work");

  // No current thread means a zero current id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> (cur_q == '0))
    else $error("current id not cleared");

  // A successful pick leaves that thread current.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPick && rd.run_hit) |=> (held_q && cur_q == $past(rd.id)))
    else $error("picked thread not made current");

endmodule
